// ===== src/hgfp_pkg.sv =====
// Shared types, constants and helper functions for the hex text gas frame parser.
// No dependencies; used by every module of the block.
package hgfp_pkg;

   localparam int CHAR_W              = 8;
   localparam int DIGIT_W             = 6;
   localparam int POS_W               = 4;
   localparam int PART_W              = 10;
   localparam int CONC_W              = 18;
   localparam int FRAME_CHARS_DEFAULT = 16;

   localparam logic [CHAR_W-1:0] CHAR_START = 8'h66;   // 'f'

   // One received character after classification.
   typedef struct packed {
      logic                accepted;
      logic                is_start;
      logic [DIGIT_W-1:0]  digit;
      logic [CHAR_W-1:0]   code;
   } decode_type;

   // Outcome of one character in the frame tracker.
   typedef struct packed {
      logic                emit;
      logic [CONC_W-1:0]   value;
   } result_type;

   // Fixed header text expected at a body position.
   typedef struct packed {
      logic                check;
      logic [CHAR_W-1:0]   code;
   } expect_type;

   // Body positions 0-3 must read "1704" and positions 10-13 must read "07d0".
   function automatic expect_type expected_char(input logic [POS_W-1:0] pos);
      expect_type e;
      e.check = 1'b1;
      case (pos)
         4'd0:    e.code = 8'h31;
         4'd1:    e.code = 8'h37;
         4'd2:    e.code = 8'h30;
         4'd3:    e.code = 8'h34;
         4'd10:   e.code = 8'h30;
         4'd11:   e.code = 8'h37;
         4'd12:   e.code = 8'h64;
         4'd13:   e.code = 8'h30;
         default: begin
            e.check = 1'b0;
            e.code  = '0;
         end
      endcase
      return e;
   endfunction

endpackage

// ===== src/hgfp_char_decode.sv =====
// Character classifier: filters digits and lowercase letters and maps them to 0-35.
// Depends on hgfp_pkg.
module hgfp_char_decode (
   input  logic [hgfp_pkg::CHAR_W-1:0] rx_char,
   output hgfp_pkg::decode_type        dec
);

   always_comb begin
      dec.code     = rx_char;
      dec.is_start = (rx_char == hgfp_pkg::CHAR_START);
      dec.accepted = 1'b0;
      dec.digit    = '0;
      if (rx_char inside {[8'h30:8'h39]}) begin
         dec.accepted = 1'b1;
         dec.digit    = hgfp_pkg::DIGIT_W'(rx_char - 8'h30);
      end else if (rx_char inside {[8'h61:8'h7a]}) begin
         dec.accepted = 1'b1;
         // 'a' maps to ten.
         dec.digit    = hgfp_pkg::DIGIT_W'(rx_char - 8'h57);
      end
   end

endmodule

// ===== src/hgfp_frame_fsm.sv =====
// Frame tracker: start detection, body position, header check and value assembly.
// Depends on hgfp_pkg; fed by hgfp_char_decode.
module hgfp_frame_fsm #(
   parameter int FRAME_CHARS = hgfp_pkg::FRAME_CHARS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  hgfp_pkg::decode_type  dec,
   output hgfp_pkg::result_type  res
);

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_ONE_F  = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   logic [1:0]                  phase_ff, phase_in;
   logic [hgfp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                        hdr_ff, hdr_in;
   logic [hgfp_pkg::PART_W-1:0] high_ff, high_in;
   logic [hgfp_pkg::PART_W-1:0] low_ff, low_in;

   logic                        hdr_upd;
   logic [hgfp_pkg::PART_W-1:0] high_upd;
   logic [hgfp_pkg::PART_W-1:0] low_upd;
   logic                        last;
   hgfp_pkg::expect_type        exp_c;

   assign exp_c = hgfp_pkg::expected_char(pos_ff);
   assign last  = ({1'b0, pos_ff} + 5'd1) >= 5'(FRAME_CHARS);

   always_comb begin
      hdr_upd  = hdr_ff;
      high_upd = high_ff;
      low_upd  = low_ff;
      if (exp_c.check && (dec.code != exp_c.code)) begin
         hdr_upd = 1'b0;
      end
      case (pos_ff)
         4'd6:    high_upd = {dec.digit, 4'b0000};
         4'd7:    high_upd = high_ff + hgfp_pkg::PART_W'(dec.digit);
         4'd8:    low_upd  = {dec.digit, 4'b0000};
         4'd9:    low_upd  = low_ff + hgfp_pkg::PART_W'(dec.digit);
         default: ;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      res.emit  = 1'b0;
      res.value = hgfp_pkg::CONC_W'({high_upd, 8'h00}) + hgfp_pkg::CONC_W'(low_upd);
      if (dec.accepted) begin
         case (phase_ff)
            PH_ONE_F: begin
               phase_in = dec.is_start ? PH_BODY : PH_SEARCH;
               pos_in   = '0;
               hdr_in   = 1'b1;
               high_in  = '0;
               low_in   = '0;
            end
            PH_BODY: begin
               if (last) begin
                  // Frame ends: report if the header held, then start over.
                  res.emit = hdr_upd;
                  phase_in = PH_SEARCH;
                  pos_in   = '0;
                  hdr_in   = 1'b1;
                  high_in  = '0;
                  low_in   = '0;
               end else begin
                  pos_in  = pos_ff + 1'b1;
                  hdr_in  = hdr_upd;
                  high_in = high_upd;
                  low_in  = low_upd;
               end
            end
            default: begin
               if (dec.is_start) begin
                  phase_in = PH_ONE_F;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         pos_ff   <= '0;
         hdr_ff   <= 1'b1;
         high_ff  <= '0;
         low_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

endmodule

// ===== src/hex_text_gas_frame_parser_unit.sv =====
// The block takes one ASCII character per item and returns the 18-bit gas
// concentration of each valid frame on the result port, through the input register
// and then the result register. A character is taken in every cycle; the input register
// stalls only when a result waits unread and the held character would finish a valid frame.
// Top level of the hex text gas frame parser: input register, decode, frame
// tracker and result register. Depends on hgfp_pkg, hgfp_char_decode, hgfp_frame_fsm.
module hex_text_gas_frame_parser_unit #(
   parameter int FRAME_CHARS = hgfp_pkg::FRAME_CHARS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [hgfp_pkg::CHAR_W-1:0]  req_rx_char,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hgfp_pkg::CONC_W-1:0]  rsp_concentration
);

   logic                        in_valid_ff;
   logic [hgfp_pkg::CHAR_W-1:0] in_char_ff;
   logic                        rsp_valid_ff;
   logic [hgfp_pkg::CONC_W-1:0] rsp_conc_ff;

   hgfp_pkg::decode_type        dec;
   hgfp_pkg::result_type        res;
   logic                        out_free;
   logic                        advance;

   hgfp_char_decode u_decode (
      .rx_char (in_char_ff),
      .dec     (dec)
   );

   hgfp_frame_fsm #(
      .FRAME_CHARS (FRAME_CHARS)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .dec   (dec),
      .res   (res)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // An item that yields nothing always moves on; one that yields a result needs room.
   assign advance   = in_valid_ff && (!res.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_rx_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.emit) begin
         rsp_conc_ff <= res.value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_concentration = rsp_conc_ff;

`ifndef SYNTHESIS
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && res.emit && rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("result register would be overwritten");

   a_conc_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_conc_ff <= 18'd152915))
      else $error("concentration out of range");

   a_load_input : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted item missing from input register");
`endif

endmodule

// ===== tb/hgfp_frame_checker.sv =====
// Scoreboard for the hex text gas frame parser: follows both channels, predicts
// the concentration of every valid frame and compares it with what the block returns.
// Depends on hgfp_pkg for widths and the start character.
module hgfp_frame_checker
   import hgfp_pkg::*;
#(
   parameter int FRAME_CHARS = FRAME_CHARS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CHAR_W-1:0] req_rx_char,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [CONC_W-1:0] rsp_concentration,
   output int                mismatch_count,
   output int                outstanding
);

   localparam logic [31:0] GAS_ID_TEXT  = "1704";
   localparam logic [31:0] MAX_UOM_TEXT = "07d0";

   typedef enum logic [1:0] {
      SYNC_HUNT  = 2'd0,
      SYNC_ONE_F = 2'd1,
      SYNC_BODY  = 2'd2
   } sync_phase_type;

   sync_phase_type    sync_phase;
   logic [POS_W-1:0]  body_pos;
   logic              header_good;
   logic [PART_W-1:0] high_part;
   logic [PART_W-1:0] low_part;
   logic [CONC_W-1:0] expected_conc_q[$];
   int                errors;

   function automatic logic is_text_char(input logic [CHAR_W-1:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return DIGIT_W'(c - "0");
      return DIGIT_W'(c - "a" + 10);
   endfunction

   task automatic clear_frame();
      body_pos    = '0;
      header_good = 1'b1;
      high_part   = '0;
      low_part    = '0;
   endtask

   // Advances the frame tracker by one character and reports a finished valid frame.
   task automatic track_char(input logic [CHAR_W-1:0] c, output logic emit,
                             output logic [CONC_W-1:0] conc);
      logic [DIGIT_W-1:0] d;
      int                 p;
      emit = 1'b0;
      conc = '0;
      if (is_text_char(c)) begin
         case (sync_phase)
            SYNC_ONE_F: begin
               sync_phase = (c == CHAR_START) ? SYNC_BODY : SYNC_HUNT;
               clear_frame();
            end
            SYNC_BODY: begin
               d = digit_of(c);
               p = int'(body_pos);
               if (p < 4) begin
                  if (c != GAS_ID_TEXT[8*(3-p) +: 8]) header_good = 1'b0;
               end else if (p >= 10 && p < 14) begin
                  if (c != MAX_UOM_TEXT[8*(13-p) +: 8]) header_good = 1'b0;
               end
               case (p)
                  6: high_part = PART_W'(d * 16);
                  7: high_part = PART_W'(high_part + d);
                  8: low_part  = PART_W'(d * 16);
                  9: low_part  = PART_W'(low_part + d);
                  default: ;
               endcase
               if (p + 1 >= FRAME_CHARS) begin
                  emit = header_good;
                  conc = CONC_W'(high_part * 256 + low_part);
                  sync_phase = SYNC_HUNT;
                  clear_frame();
               end else begin
                  body_pos = POS_W'(p + 1);
               end
            end
            default: begin
               if (c == CHAR_START) sync_phase = SYNC_ONE_F;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : monitor
      logic              emit;
      logic [CONC_W-1:0] conc;
      logic [CONC_W-1:0] want;
      if (reset) begin
         sync_phase = SYNC_HUNT;
         clear_frame();
         expected_conc_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_conc_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("concentration %0d returned with no valid frame pending",
                           rsp_concentration);
            end else begin
               want = expected_conc_q.pop_front();
               if (rsp_concentration !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("concentration mismatch: expected %0d, got %0d",
                              want, rsp_concentration);
               end
            end
         end
         if (req_valid && req_ready) begin
            track_char(req_rx_char, emit, conc);
            if (emit) expected_conc_q.insert(expected_conc_q.size(), conc);
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_conc_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the gas frame parser testbench: clock, reset, character stimulus and
// result-side flow control around the block. Depends on hgfp_pkg,
// hex_text_gas_frame_parser_unit and hgfp_frame_checker.
module tb_top;
   import hgfp_pkg::*;

   localparam int BODY_LEN     = FRAME_CHARS_DEFAULT;
   localparam int TARGET_ITEMS = 650;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [31:0] GAS_ID_TEXT  = "1704";
   localparam logic [31:0] MAX_UOM_TEXT = "07d0";

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_TOGGLE,
      READY_SPARSE
   } ready_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [CHAR_W-1:0] req_rx_char;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CONC_W-1:0] rsp_concentration;
   int                mismatch_count;
   int                outstanding;
   int                idle_cycles;
   logic              hold_go;

   logic [CHAR_W-1:0] tx_chars[$];
   int                text_items;

   hex_text_gas_frame_parser_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_char       (req_rx_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_concentration (rsp_concentration)
   );

   hgfp_frame_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_char       (req_rx_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_concentration (rsp_concentration),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: too many cycles without any item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [CHAR_W-1:0] rand_text_char();
      int d;
      d = $urandom_range(0, 35);
      return (d < 10) ? CHAR_W'("0" + d) : CHAR_W'("a" + d - 10);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_ignored_char();
      case ($urandom_range(0, 2))
         0:       return CHAR_W'($urandom_range(8'h00, 8'h2f));
         1:       return CHAR_W'($urandom_range(8'h3a, 8'h60));
         default: return CHAR_W'($urandom_range(8'h7b, 8'hff));
      endcase
   endfunction

   // Appends one byte to the send queue.
   task automatic append_char(input logic [CHAR_W-1:0] c);
      tx_chars.insert(tx_chars.size(), c);
   endtask

   // Queues one character the parser acts on, now and then behind a line-noise byte.
   task automatic put_text(input logic [CHAR_W-1:0] c);
      if ($urandom_range(0, 11) == 0) append_char(rand_ignored_char());
      append_char(c);
      text_items++;
   endtask

   task automatic put_frame(input bit flawed, input logic [31:0] digits);
      logic [CHAR_W-1:0] body [BODY_LEN];
      logic [CHAR_W-1:0] c;
      int                bad_pos;
      for (int i = 0; i < BODY_LEN; i++) body[i] = rand_text_char();
      for (int i = 0; i < 4; i++) begin
         body[i]      = GAS_ID_TEXT[8*(3-i) +: 8];
         body[6 + i]  = digits[8*(3-i) +: 8];
         body[10 + i] = MAX_UOM_TEXT[8*(3-i) +: 8];
      end
      if (flawed) begin
         bad_pos = $urandom_range(0, 7);
         if (bad_pos >= 4) bad_pos += 6;
         do c = rand_text_char(); while (c == body[bad_pos]);
         body[bad_pos] = c;
      end
      put_text(CHAR_START);
      put_text(CHAR_START);
      for (int i = 0; i < BODY_LEN; i++) put_text(body[i]);
   endtask

   // Offers every queued character in bursts of random length with random gaps.
   task automatic send_all();
      int burst;
      int gap;
      while (tx_chars.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && tx_chars.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_char <= tx_chars.pop_front();
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         // Drop the valid line and wait before returning so that the next call
         // does not drive the valid line again in the same time step.
         if (gap == 0 && tx_chars.size() == 0) gap = 1;
         if (gap != 0 || tx_chars.size() == 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_results_done();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : receiver
      ready_mode_type mode;
      int             mode_left;
      bit             hold_done;
      rsp_ready = 1'b0;
      mode      = READY_ALWAYS;
      mode_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_TOGGLE: rsp_ready <= ~rsp_ready;
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin : stimulus
      logic [31:0] digits;
      int          pick;
      bit          pause_done;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_char = '0;
      hold_go     = 1'b0;
      text_items  = 0;
      pause_done  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Bytes just outside the accepted ranges, an upper-case start letter,
      // a start letter followed by something else, then the largest and the
      // smallest concentration.
      append_char(8'h00);
      append_char(8'hff);
      append_char(8'h2f);
      append_char(8'h3a);
      append_char(8'h60);
      append_char(8'h7b);
      append_char(8'h46);
      put_text(CHAR_START);
      put_text("1");
      put_frame(1'b0, "zzzz");
      put_frame(1'b0, "0000");
      send_all();

      while (text_items < TARGET_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) begin
               digits = ($urandom_range(0, 1) == 0) ? "zzzz" : "0000";
            end else begin
               digits = {rand_text_char(), rand_text_char(), rand_text_char(),
                         rand_text_char()};
            end
            put_frame(1'b0, digits);
         end else if (pick < 70) begin
            put_frame(1'b1, {rand_text_char(), rand_text_char(), rand_text_char(),
                             rand_text_char()});
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 8)) append_char(CHAR_W'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            put_text(CHAR_START);
            do digits[7:0] = rand_text_char(); while (digits[7:0] == CHAR_START);
            put_text(digits[7:0]);
         end else begin
            // A third start letter becomes the first body character.
            put_text(CHAR_START);
            put_frame(1'b0, {rand_text_char(), rand_text_char(), rand_text_char(),
                             rand_text_char()});
         end
         if (text_items > 250 && !hold_go) hold_go = 1'b1;
         if (tx_chars.size() >= 60) send_all();
         if (text_items > 420 && !pause_done) begin
            send_all();
            wait_results_done();
            pause_done = 1'b1;
         end
      end
      send_all();

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
